@@ rtl/bls_pkg.sv @@
// ----------------------------------------------------------------------------
// bls_pkg: shared types and constants of the byte list sorter
// Command word passed from the front end to the back end, plus defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package bls_pkg;

  localparam int unsigned ByteW           = 8;
  localparam int unsigned CapacityDefault = 16;
  localparam int unsigned QueueDepth      = 2;

  // One classified input transaction.
  typedef struct packed {
    logic [ByteW-1:0] value;   // byte carried by the transaction
    logic             store;   // byte fits and goes into the list
    logic             is_end;  // final byte of the list
    logic             err;     // list ran past capacity (only with is_end)
  } cmd_t;

endpackage : bls_pkg

`default_nettype wire

@@ rtl/bls_front.sv @@
// ----------------------------------------------------------------------------
// bls_front: input side of the byte list sorter
// Accepts bytes, tracks the list length and flags lists over capacity.
// ----------------------------------------------------------------------------
`default_nettype none

module bls_front
  import bls_pkg::*;
#(
  parameter int unsigned CAPACITY = CapacityDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [ByteW-1:0] in_value_i,
  input  wire logic             in_last_i,
  output logic                  push_o,
  output cmd_t                  cmd_o,
  input  wire logic             q_full_i
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovf_q, ovf_d;
  logic            fits;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;
  assign fits       = cnt_q < CntW'(CAPACITY);

  always_comb begin
    cmd_o.value  = in_value_i;
    cmd_o.store  = fits;
    cmd_o.is_end = in_last_i;
    cmd_o.err    = in_last_i && (ovf_q || !fits);
  end

  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (push_o) begin
      if (in_last_i) begin
        cnt_d = '0;
        ovf_d = 1'b0;
      end else if (fits) begin
        cnt_d = cnt_q + 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

endmodule : bls_front

`default_nettype wire

@@ rtl/bls_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// bls_cmd_fifo: command queue between front and back end
// Small register FIFO; lets either side stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module bls_cmd_fifo
  import bls_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t wdata_i,
  output logic      full_o,
  input  wire logic pop_i,
  output cmd_t      rdata_o,
  output logic      valid_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CntW'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign rdata_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule : bls_cmd_fifo

`default_nettype wire

@@ rtl/bls_back.sv @@
// ----------------------------------------------------------------------------
// bls_back: sorting back end of the byte list sorter
// Ordered insertion row of cells; drained one byte per cycle unless output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module bls_back
  import bls_pkg::*;
#(
  parameter int unsigned CAPACITY = CapacityDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_valid_i,
  input  wire cmd_t             q_cmd_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [ByteW-1:0]      out_value_o,
  output logic                  out_last_o,
  output logic                  out_err_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  localparam logic [1:0] StLoad  = 2'd0;
  localparam logic [1:0] StDrain = 2'd1;
  localparam logic [1:0] StErr   = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [ByteW-1:0] cell_q [CAPACITY];
  logic [ByteW-1:0] cell_d [CAPACITY];
  logic [ByteW-1:0] ins_val [CAPACITY];
  logic [ByteW-1:0] shr_val [CAPACITY];
  logic             le [CAPACITY];
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_value_q, out_value_d;
  logic             out_last_q, out_last_d;
  logic             out_err_q, out_err_d;
  logic             out_free;

  // per-cell insert and shift-down candidates
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign le[i] = (CntW'(i) < cnt_q) && (cell_q[i] <= q_cmd_i.value);
    if (i == 0) begin : g_first
      assign ins_val[i] = le[i] ? cell_q[i] : q_cmd_i.value;
    end else begin : g_rest
      assign ins_val[i] = le[i] ? cell_q[i] : (le[i-1] ? q_cmd_i.value : cell_q[i-1]);
    end
    if (i == CAPACITY - 1) begin : g_top
      assign shr_val[i] = cell_q[i];
    end else begin : g_mid
      assign shr_val[i] = cell_q[i+1];
    end
  end

  assign pop_o    = q_valid_i && (state_q == StLoad);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cell_d      = cell_q;
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;
    out_err_d   = out_err_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StLoad: begin
        if (pop_o) begin
          if (q_cmd_i.store) begin
            cell_d = ins_val;
            cnt_d  = cnt_q + 1'b1;
          end
          if (q_cmd_i.is_end) begin
            state_d = q_cmd_i.err ? StErr : StDrain;
          end
        end
      end
      StDrain: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = cell_q[0];
          out_last_d  = cnt_q == CntW'(1);
          out_err_d   = 1'b0;
          cell_d      = shr_val;
          cnt_d       = cnt_q - 1'b1;
          if (cnt_q == CntW'(1)) begin
            state_d = StLoad;
          end
        end
      end
      StErr: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = '0;
          out_last_d  = 1'b1;
          out_err_d   = 1'b1;
          cnt_d       = '0;
          state_d     = StLoad;
        end
      end
      default: begin
        state_d = StLoad;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    cell_q      <= cell_d;
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
    out_err_q   <= out_err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;
  assign out_err_o   = out_err_q;

endmodule : bls_back

`default_nettype wire

@@ rtl/byte_list_ascending_sorter.sv @@
// ----------------------------------------------------------------------------
// byte_list_ascending_sorter: sorts a list of bytes into ascending order
// Front end classifies bytes, a command queue decouples it from the back end,
// which keeps an ordered insertion row and streams it out when the list ends.
// ----------------------------------------------------------------------------
//
//   channel  dir  tdata           tlast     tuser
//   s_axis   in   value[7:0]      last      -
//   m_axis   out  sorted_value    is_last   error
//
// Each byte is inserted into the ordered cell row as it is popped from the
// queue (one compare per cell); once a list ends within capacity, the row
// drains one byte per cycle from the lowest cell while m_axis_tready does
// not stall the output register. An over-capacity list answers with a
// single error transaction.
// Reset clears counters, queue and output valid; cell contents are not reset.
// Input stalls only when the two-entry command queue is full; the output
// register lets the back end hold while m_axis_tready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_list_ascending_sorter
  import bls_pkg::*;
#(
  parameter int unsigned CAPACITY = CapacityDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // input stream
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [ByteW-1:0] s_axis_tdata,   // [7:0] value
  input  wire logic             s_axis_tlast,   // last byte of the list
  // output stream
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [ByteW-1:0]      m_axis_tdata,   // [7:0] sorted_value
  output logic                  m_axis_tlast,   // is_last
  output logic                  m_axis_tuser    // [0] error
);

  cmd_t push_cmd, pop_cmd;
  logic push, q_full, pop, q_valid;

  // front end: length tracking and overflow classification
  bls_front #(
    .CAPACITY (CAPACITY)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_value_i (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .push_o     (push),
    .cmd_o      (push_cmd),
    .q_full_i   (q_full)
  );

  // decoupling queue
  bls_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .rdata_o (pop_cmd),
    .valid_o (q_valid)
  );

  // back end: ordered insertion and drain
  bls_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (pop_cmd),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_value_o (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_err_o   (m_axis_tuser)
  );

  // error result is a lone, zero-valued, final transaction
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
    else $error("error result not shaped as a single last transaction");

  // drain keeps the output stream busy until the final byte
  a_drain_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("gap inside a sorted list");

  // bytes within a list come out in ascending order
  a_ascending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tdata >= $past(m_axis_tdata))
    else $error("sorted output went down");

endmodule : byte_list_ascending_sorter

`default_nettype wire
